// ----- design/vwcbp_pkg.sv -----
// Package for the variable-width code byte packer.
// Holds the field widths, the operation codes and the structs passed between stages.
// No dependencies; every other design file imports it.
package vwcbp_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int WIDTH_W = 5;
    localparam int CNT_W   = 3;
    localparam int PEND_W  = 7;
    localparam int ACC_W   = 23;

    localparam logic [WIDTH_W-1:0] MIN_CODE_WIDTH = 5'd8;
    localparam logic [WIDTH_W-1:0] MAX_CODE_WIDTH = 5'd16;

    typedef enum logic
    {
        OP_PACK  = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // Item held in the input register.
    typedef struct packed
    {
        logic               valid;
        logic               op;
        logic [CODE_W-1:0]  code;
        logic [WIDTH_W-1:0] code_width;
    } item_t;

    // Bytes produced by one item: n is 0, 1 or 2.
    typedef struct packed
    {
        logic [1:0]        n;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
    } pack_res_t;

    // Handshake from the result register back to the earlier stages.
    typedef struct packed
    {
        logic take;
    } adv_t;

    // Status of the result register.
    typedef struct packed
    {
        logic [1:0] count;
    } out_stat_t;

    // Status of the leftover state.
    typedef struct packed
    {
        logic [CNT_W-1:0] count;
    } left_stat_t;

endpackage

// ----- design/vwcbp_if.sv -----
// Channel interfaces of the code byte packer: the code input and the byte output.
// Depends on vwcbp_pkg for the field widths.
interface vwcbp_code_if;
    import vwcbp_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] code_width;

    modport source (output valid, output op, output code, output code_width, input ready);
    modport sink   (input valid, input op, input code, input code_width, output ready);
endinterface

interface vwcbp_byte_if;
    import vwcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ----- design/vwcbp_input_stage.sv -----
// Input register of the code byte packer: holds one accepted beat until it is packed.
// Depends on vwcbp_pkg and vwcbp_if.
module vwcbp_input_stage
(
    input  logic               clk,
    input  logic               rst_n,
    vwcbp_code_if.sink         codes,
    input  vwcbp_pkg::adv_t    adv,
    output vwcbp_pkg::item_t   item
);
    import vwcbp_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic               op_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic               accept;

    // The register frees up whenever its item moves on to the result register.
    assign codes.ready = !valid_reg || adv.take;
    assign accept      = codes.valid && codes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (adv.take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= codes.op;
            code_reg  <= codes.code;
            width_reg <= codes.code_width;
        end
    end

    assign item.valid      = valid_reg;
    assign item.op         = op_reg;
    assign item.code       = code_reg;
    assign item.code_width = width_reg;

endmodule

// ----- design/vwcbp_pack_logic.sv -----
// Packing logic: joins the leftover bits with the held code and cuts whole bytes.
// Keeps the leftover bits and their count. Depends on vwcbp_pkg.
module vwcbp_pack_logic
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  vwcbp_pkg::item_t       item,
    input  vwcbp_pkg::adv_t        adv,
    output vwcbp_pkg::pack_res_t   res,
    output vwcbp_pkg::left_stat_t  stat
);
    import vwcbp_pkg::*;

    logic [PEND_W-1:0]  left_bits_reg;
    logic [PEND_W-1:0]  left_bits_next;
    logic [CNT_W-1:0]   left_count_reg;
    logic [CNT_W-1:0]   left_count_next;

    logic [WIDTH_W-1:0] width;
    logic [ACC_W-1:0]   code_mask;
    logic [ACC_W-1:0]   acc;
    logic [WIDTH_W-1:0] total;
    logic [WIDTH_W-1:0] rest1;
    logic [WIDTH_W-1:0] rest2;
    logic [ACC_W-1:0]   shift1;
    logic [ACC_W-1:0]   shift2;
    logic [BYTE_W-1:0]  flush_byte;
    logic [BYTE_W-1:0]  keep_mask;
    logic [CNT_W-1:0]   keep_count;
    logic               update;

    // Clamp the code width into the legal range.
    always_comb
    begin
        if (item.code_width < MIN_CODE_WIDTH)
        begin
            width = MIN_CODE_WIDTH;
        end
        else if (item.code_width > MAX_CODE_WIDTH)
        begin
            width = MAX_CODE_WIDTH;
        end
        else
        begin
            width = item.code_width;
        end
    end

    // Append the code below the leftover bits and locate the byte boundaries.
    assign code_mask = (ACC_W'(1) << width) - ACC_W'(1);
    assign acc       = (ACC_W'(left_bits_reg) << width)
                     | (ACC_W'(item.code) & code_mask);
    assign total     = WIDTH_W'(left_count_reg) + width;
    assign rest1     = total - WIDTH_W'(BYTE_W);
    assign rest2     = rest1 - WIDTH_W'(BYTE_W);
    assign shift1    = acc >> rest1;
    assign shift2    = acc >> rest2;

    // Pending bits left-aligned in one byte for a flush.
    assign flush_byte = BYTE_W'({1'b0, left_bits_reg}
                        << (4'(BYTE_W) - {1'b0, left_count_reg}));

    assign keep_count = (rest1 >= WIDTH_W'(BYTE_W)) ? rest2[CNT_W-1:0] : rest1[CNT_W-1:0];
    assign keep_mask  = (BYTE_W'(1) << keep_count) - BYTE_W'(1);

    always_comb
    begin
        res.byte0       = shift1[BYTE_W-1:0];
        res.byte1       = shift2[BYTE_W-1:0];
        left_bits_next  = acc[PEND_W-1:0] & keep_mask[PEND_W-1:0];
        left_count_next = keep_count;
        res.n           = (rest1 >= WIDTH_W'(BYTE_W)) ? 2'd2 : 2'd1;
        if (op_t'(item.op) == OP_FLUSH)
        begin
            res.byte0       = flush_byte;
            res.byte1       = flush_byte;
            left_bits_next  = '0;
            left_count_next = '0;
            res.n           = (left_count_reg == '0) ? 2'd0 : 2'd1;
        end
    end

    assign update = item.valid && adv.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_bits_reg  <= '0;
            left_count_reg <= '0;
        end
        else if (update)
        begin
            left_bits_reg  <= left_bits_next;
            left_count_reg <= left_count_next;
        end
    end

    assign stat.count = left_count_reg;

endmodule

// ----- design/vwcbp_output_stage.sv -----
// Result register: holds up to two bytes of one item and sends them one beat at a time.
// Depends on vwcbp_pkg and vwcbp_if.
module vwcbp_output_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vwcbp_pkg::item_t      item,
    input  vwcbp_pkg::pack_res_t  res,
    output vwcbp_pkg::adv_t       adv,
    output vwcbp_pkg::out_stat_t  stat,
    vwcbp_byte_if.source          stream
);
    import vwcbp_pkg::*;

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic [BYTE_W-1:0] slot0_reg;
    logic [BYTE_W-1:0] slot0_next;
    logic              last0_reg;
    logic              last0_next;
    logic [BYTE_W-1:0] slot1_reg;
    logic [BYTE_W-1:0] slot1_next;
    logic              pop;
    logic              load;

    assign pop      = stream.valid && stream.ready;
    // A new item may enter once the register is empty or sends its final beat now.
    assign adv.take = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop);
    assign load     = adv.take && item.valid;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        last0_next = last0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            count_next = res.n;
            slot0_next = res.byte0;
            last0_next = (res.n == 2'd1);
            slot1_next = res.byte1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
            last0_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        last0_reg <= last0_next;
        slot1_reg <= slot1_next;
    end

    assign stream.valid    = (count_reg != 2'd0);
    assign stream.out_byte = slot0_reg;
    assign stream.last     = last0_reg;
    assign stat.count      = count_reg;

endmodule

// ----- design/variable_width_code_byte_packer_core.sv -----
// Variable-width code byte packer, MSB first.
// Codes of 8 to 16 bits arrive as beats on the codes channel (op, code, code_width)
// and leave as a byte stream on the stream channel (out_byte, last), one byte a beat.
// A pack beat yields one or two bytes; a flush beat yields the pending bits
// left-aligned and zero padded in one byte, or no byte when nothing is pending.
// The final byte caused by each beat carries last.
// A byte passes through the input register, then the result register, before it
// is offered on the stream channel.
// Throughput: one beat per cycle while each yields at most one byte and the receiver
// takes every byte; a beat that yields two bytes holds the result register until
// its second byte is taken, so the beat behind it waits.
// The result register decouples the channels: a new beat is taken while the
// last byte of the previous one waits to be taken.
// When the receiver stalls, the result register holds its byte and, once the
// input register is full as well, codes.ready falls.
// Reset clears the leftover bits and their count, the input valid flag and the
// byte count; no byte is offered after reset until a beat arrives.
// Depends on vwcbp_pkg, vwcbp_if and the three stage modules.
module variable_width_code_byte_packer_core
(
    input  logic         clk,
    input  logic         rst_n,
    vwcbp_code_if.sink   codes,
    vwcbp_byte_if.source stream
);
    import vwcbp_pkg::*;

    item_t      item;
    adv_t       adv;
    pack_res_t  res;
    out_stat_t  out_stat;
    left_stat_t left_stat;

    vwcbp_input_stage u_input
    (
        .clk   (clk),
        .rst_n (rst_n),
        .codes (codes),
        .adv   (adv),
        .item  (item)
    );

    vwcbp_pack_logic u_pack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .adv   (adv),
        .res   (res),
        .stat  (left_stat)
    );

    vwcbp_output_stage u_output
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .res    (res),
        .adv    (adv),
        .stat   (out_stat),
        .stream (stream)
    );

    // The result register never holds more than two bytes.
    assert property (@(posedge clk) disable iff (!rst_n) out_stat.count != 2'd3)
        else $error("result register holds more than two bytes");

    // A byte without last is always followed by a second byte already held.
    assert property (@(posedge clk) disable iff (!rst_n)
        stream.valid && !stream.last |-> out_stat.count == 2'd2)
        else $error("non-final byte offered without its successor");

    // A flush that moves on leaves no pending bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && adv.take && (op_t'(item.op) == OP_FLUSH) |=> left_stat.count == '0)
        else $error("pending bits remain after flush");

    // An accepted beat is held in the input register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        codes.valid && codes.ready |=> item.valid)
        else $error("accepted beat lost");

endmodule
